>>> rtl/smpr_pkg.sv
// Shared constants, types and helper functions of the second-max pooling reducer.
package smpr_pkg;

	localparam int MAX_LOG_SIZE = 8;
	localparam int DATA_W       = 32;
	localparam int LOG_W        = 4;
	localparam int COL_W        = MAX_LOG_SIZE;
	localparam int PAIR_AW      = MAX_LOG_SIZE - 1;
	localparam int PAIR_DEPTH   = 2 ** PAIR_AW;
	localparam int CNT_W        = 2 * MAX_LOG_SIZE;
	localparam int FIFO_DEPTH   = 2;
	localparam int FIFO_CNT_W   = 2;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [0:0]       REG_LOG_SIZE   = 1'b0;
	localparam logic [LOG_W-1:0] LOG_SIZE_RESET = LOG_W'(8);

	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
	} cell_bus_t;

	typedef struct packed {
		logic             restart;
		logic [LOG_W-1:0] lg;
	} cell_ctl_t;

	// Clamp the programmed size into the supported range.
	function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] raw);
		logic [LOG_W-1:0] lg;
		lg = raw;
		if (lg == '0) lg = LOG_W'(1);
		if (lg > LOG_W'(MAX_LOG_SIZE)) lg = LOG_W'(MAX_LOG_SIZE);
		return lg;
	endfunction

	// Last column index of a row of side 2^lg.
	function automatic logic [COL_W-1:0] col_last(input logic [LOG_W-1:0] lg);
		return ~({COL_W{1'b1}} << lg);
	endfunction

	// Last sample index of a matrix of side 2^lg.
	function automatic logic [CNT_W-1:0] cnt_last(input logic [LOG_W-1:0] lg);
		return ~({CNT_W{1'b1}} << {lg, 1'b0});
	endfunction

	function automatic logic signed [DATA_W-1:0] max_s(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic signed [DATA_W-1:0] min_s(input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	// Second largest of four values, equal values counted separately.
	function automatic logic signed [DATA_W-1:0] second_of_four(
			input logic signed [DATA_W-1:0] a, input logic signed [DATA_W-1:0] b,
			input logic signed [DATA_W-1:0] c, input logic signed [DATA_W-1:0] d);
		return max_s(min_s(max_s(a, b), max_s(c, d)), max_s(min_s(a, b), min_s(c, d)));
	endfunction

endpackage

>>> rtl/smpr_ifs.sv
// Valid/ready stream interfaces for the sample input and the pooled result output.
interface smpr_sample_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [smpr_pkg::DATA_W-1:0]       sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);
endinterface

interface smpr_pooled_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [smpr_pkg::DATA_W-1:0]       pooled_value;

	modport source (output valid, output pooled_value, input ready);
	modport sink (input valid, input pooled_value, output ready);
endinterface

>>> rtl/smpr_cell.sv
// One pooling level: even-row buffer, pending left value and the 2x2 second-max reduction.
module smpr_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  smpr_pkg::cell_ctl_t  ctl,
	input  smpr_pkg::cell_bus_t  din,
	output smpr_pkg::cell_bus_t  dout
);

	logic [smpr_pkg::COL_W-1:0]          col_q;
	logic                                odd_q;
	logic                                out_valid_q;
	logic signed [smpr_pkg::DATA_W-1:0]  out_value_q;
	logic signed [smpr_pkg::DATA_W-1:0]  left_q;
	logic signed [smpr_pkg::DATA_W-1:0]  pair_lo_q;
	logic signed [smpr_pkg::DATA_W-1:0]  pair_hi_q;
	logic signed [smpr_pkg::DATA_W-1:0]  mem_lo_q [smpr_pkg::PAIR_DEPTH];
	logic signed [smpr_pkg::DATA_W-1:0]  mem_hi_q [smpr_pkg::PAIR_DEPTH];

	logic [smpr_pkg::PAIR_AW-1:0] pair_addr;
	logic                         row_end;
	logic                         wr_even_row;
	logic                         take_left;
	logic                         take_right;

	assign pair_addr   = col_q[smpr_pkg::COL_W-1:1];
	assign row_end     = (col_q == smpr_pkg::col_last(ctl.lg));
	assign wr_even_row = din.valid && !odd_q;
	assign take_left   = din.valid && odd_q && !col_q[0];
	assign take_right  = din.valid && odd_q && col_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			odd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ctl.restart) begin
			col_q       <= '0;
			odd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= take_right;
			if (din.valid) begin
				if (row_end) begin
					col_q <= '0;
					odd_q <= ~odd_q;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// The even row is kept as column pairs so that both partners read out together.
	always_ff @(posedge clk) begin
		if (wr_even_row && !col_q[0]) begin
			mem_lo_q[pair_addr] <= din.value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_even_row && col_q[0]) begin
			mem_hi_q[pair_addr] <= din.value;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			left_q    <= din.value;
			pair_lo_q <= mem_lo_q[pair_addr];
			pair_hi_q <= mem_hi_q[pair_addr];
		end
		if (take_right) begin
			out_value_q <= smpr_pkg::second_of_four(pair_lo_q, pair_hi_q, left_q, din.value);
		end
	end

	assign dout.valid = out_valid_q;
	assign dout.value = out_value_q;

endmodule

>>> rtl/second_max_pooling_reduce.sv
// Top level: configuration port, chain of pooling level cells and result queue.
// The result of a matrix is registered once in each of the eff_log level cells, where
// eff_log is the clamped log_size, the first one at the transfer edge of its last
// sample, and once more in the queue. Throughput: one sample per cycle, set by every
// level cell taking one value per cycle; a matrix's last sample waits for queue room.
// Reset (arst_n low, asynchronous): log_size returns to 8, all level positions and the
// sample count clear, the result queue empties. Row buffers are not cleared.
module second_max_pooling_reduce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smpr_pkg::APB_AW-1:0]   paddr,
	input  logic [smpr_pkg::APB_DW-1:0]   pwdata,
	output logic [smpr_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	smpr_sample_if.sink                   sample_in,
	smpr_pooled_if.source                 pooled_out
);

	// Configuration register. A write restarts the stream: every level cell forgets
	// its position and the partial matrix is dropped.
	logic [smpr_pkg::LOG_W-1:0] log_size_q;
	logic                       cfg_wr;
	logic                       reg_hit;
	logic [smpr_pkg::LOG_W-1:0] eff;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[smpr_pkg::APB_AW-1] == smpr_pkg::REG_LOG_SIZE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? smpr_pkg::APB_DW'(log_size_q) : '0;
	assign eff     = smpr_pkg::eff_log(log_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_size_q <= smpr_pkg::LOG_SIZE_RESET;
		end else if (cfg_wr) begin
			log_size_q <= pwdata[smpr_pkg::LOG_W-1:0];
		end
	end

	// Sample counter. It marks the transfer that completes a matrix, which is the one
	// transfer that will later produce a result.
	logic [smpr_pkg::CNT_W-1:0]      cnt_q;
	logic                            in_xfer;
	logic                            last_sample;
	logic [smpr_pkg::FIFO_CNT_W-1:0] credit_q;
	logic                            out_xfer;

	assign last_sample     = (cnt_q == smpr_pkg::cnt_last(eff));
	assign in_xfer         = sample_in.valid && sample_in.ready;
	assign out_xfer        = pooled_out.valid && pooled_out.ready;

	// Results that are still in the chain or waiting in the queue are counted. A
	// sample that closes a matrix is only taken while the queue is sure to have room
	// for its result, so every other sample flows even while a result waits.
	assign sample_in.ready = !(last_sample &&
		(credit_q == smpr_pkg::FIFO_CNT_W'(smpr_pkg::FIFO_DEPTH)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_wr) begin
			cnt_q <= '0;
		end else if (in_xfer) begin
			cnt_q <= last_sample ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({in_xfer && last_sample, out_xfer})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	// Chain of level cells. Cell i pools a matrix of side 2^(eff - i) and hands each
	// pooled value to cell i + 1 in the next cycle. Cells beyond the active depth
	// receive nothing.
	smpr_pkg::cell_ctl_t ctl  [smpr_pkg::MAX_LOG_SIZE];
	smpr_pkg::cell_bus_t din  [smpr_pkg::MAX_LOG_SIZE];
	smpr_pkg::cell_bus_t dout [smpr_pkg::MAX_LOG_SIZE];

	for (genvar i = 0; i < smpr_pkg::MAX_LOG_SIZE; i++) begin : g_level
		assign ctl[i].restart = cfg_wr;
		assign ctl[i].lg      = eff - smpr_pkg::LOG_W'(i);

		if (i == 0) begin : g_head
			assign din[i].valid = in_xfer;
			assign din[i].value = sample_in.sample_value;
		end else begin : g_link
			assign din[i].valid = dout[i-1].valid && (smpr_pkg::LOG_W'(i) < eff);
			assign din[i].value = dout[i-1].value;
		end

		smpr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.din    (din[i]),
			.dout   (dout[i])
		);
	end

	// The last active cell delivers the final value of each matrix.
	smpr_pkg::cell_bus_t res;

	always_comb begin
		res = '0;
		for (int i = 0; i < smpr_pkg::MAX_LOG_SIZE; i++) begin
			if (smpr_pkg::LOG_W'(i + 1) == eff) res = dout[i];
		end
	end

	// Two-entry result queue; the credit count above keeps it from overflowing.
	logic signed [smpr_pkg::DATA_W-1:0] fifo_q [smpr_pkg::FIFO_DEPTH];
	logic                               wr_ptr_q;
	logic                               rd_ptr_q;
	logic [smpr_pkg::FIFO_CNT_W-1:0]    fill_q;

	always_ff @(posedge clk) begin
		if (res.valid) begin
			fifo_q[wr_ptr_q] <= res.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (res.valid) wr_ptr_q <= ~wr_ptr_q;
			if (out_xfer) rd_ptr_q <= ~rd_ptr_q;
			case ({res.valid, out_xfer})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	assign pooled_out.valid        = (fill_q != '0);
	assign pooled_out.pooled_value = fifo_q[rd_ptr_q];

endmodule
